### design/paf_pkg.sv
// Shared constants and types for the packed action field unpacker.
package paf_pkg;

	localparam int SLOT_COUNT_DEFAULT = 20;
	localparam int ID_BITS_DEFAULT    = 5;
	localparam int VALUE_BITS_DEFAULT = 10;

	localparam int THRESH_BITS  = 5;
	localparam logic [THRESH_BITS-1:0] THRESH_RESET = 5'd16;

	localparam int BYTE_BITS  = 8;
	localparam int STORE_BITS = 16;
	localparam int ACC_BITS   = STORE_BITS + BYTE_BITS;
	localparam int HELD_BITS  = $clog2(ACC_BITS + 1);

	// Field widths of one result entry.
	localparam int SLOT_IDX_BITS = 5;
	localparam int ACT_ID_BITS   = 5;
	localparam int AVALUE_BITS   = 10;

	// Worst case of the parameter ranges, used to size the output casts.
	localparam int ID_BITS_MAX    = 8;
	localparam int VALUE_BITS_MAX = 16;
	localparam int SLOT_EXT_BITS  = 6;

	localparam int MAX_RESULTS = 2;
	localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam int TDATA_BITS = 24;

	typedef struct packed {
		logic [SLOT_IDX_BITS-1:0] slot_index;
		logic                     is_analog;
		logic [ACT_ID_BITS-1:0]   action_id;
		logic [AVALUE_BITS-1:0]   analog_value;
		logic                     body_done;
		logic                     last_of_run;
	} result_t;

endpackage

### design/packed_action_field_unpacker.sv
// Top level: input register, field decode and result queue of the action field unpacker.
//
// Usage:
// Body bytes enter on the s_t* group: s_tdata carries the byte, s_tuser marks the first
// byte of a new body. Decoded slot entries leave on the m_t* group, one entry per
// request; m_tlast marks the final entry produced by one byte. The analog threshold
// is written through cfg_wr_en / cfg_wr_data while the block is idle.
// Path: an accepted byte is held in the input register, decoded into the result
// queue, and its first entry is then offered on the m_t* group from the queue head.
// Throughput: one byte per cycle while each byte yields at most one entry and the
// queue has room; the output side moves one entry per cycle while m_tready is high.
// A four-entry result queue decouples the two sides; the decode stage waits until
// the queue has room for two entries.
// Reset: the queue empties, the threshold returns to 16, and the block ignores
// bytes until one arrives with the start flag set.
// Stall: when the receiver holds m_tready low, the queue fills, the decode stage
// stops and s_tready falls; no entry is lost or repeated.
module packed_action_field_unpacker #(
	parameter int SLOT_COUNT = paf_pkg::SLOT_COUNT_DEFAULT,
	parameter int ID_BITS    = paf_pkg::ID_BITS_DEFAULT,
	parameter int VALUE_BITS = paf_pkg::VALUE_BITS_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [paf_pkg::THRESH_BITS-1:0]      cfg_wr_data,  // analog_id_threshold
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [paf_pkg::BYTE_BITS-1:0]        s_tdata,      // [7:0] body_byte
	input  logic                                 s_tuser,      // [0] body_start
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [4:0] slot_index, [9:5] action_id, [19:10] analog_value, [20] body_done, [23:21] zero
	output logic [paf_pkg::TDATA_BITS-1:0]       m_tdata,
	output logic                                 m_tuser,      // [0] is_analog
	output logic                                 m_tlast       // last_of_run
);

	logic [paf_pkg::THRESH_BITS-1:0] thresh_q;

	logic                          valid_s1;
	logic [paf_pkg::BYTE_BITS-1:0] byte_s1;
	logic                          start_s1;
	logic                          fire;

	paf_pkg::result_t              res [paf_pkg::MAX_RESULTS];
	logic [paf_pkg::CNT_BITS-1:0]  res_count;

	paf_pkg::result_t              fifo_q [paf_pkg::FIFO_DEPTH];
	logic [paf_pkg::FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [paf_pkg::FIFO_CW-1:0]   cnt_q;
	logic                          pop;
	paf_pkg::result_t              head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= paf_pkg::THRESH_RESET;
		end else if (cfg_wr_en) begin
			thresh_q <= cfg_wr_data;
		end
	end

	// The decode stage only runs when the queue can take both entries of a byte.
	assign fire     = valid_s1 &&
		(cnt_q <= paf_pkg::FIFO_CW'(paf_pkg::FIFO_DEPTH - paf_pkg::MAX_RESULTS));
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	paf_unpack #(
		.SLOT_COUNT (SLOT_COUNT),
		.ID_BITS    (ID_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_unpack (
		.clk       (clk),
		.arst_n    (arst_n),
		.threshold (thresh_q),
		.fire      (fire),
		.byte_in   (byte_s1),
		.start     (start_s1),
		.res       (res),
		.res_count (res_count)
	);

	assign pop = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (fire) begin
				wr_ptr_q <= wr_ptr_q + paf_pkg::FIFO_AW'(res_count);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (fire ? paf_pkg::FIFO_CW'(res_count) : '0)
				- paf_pkg::FIFO_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (fire && (res_count != '0)) begin
			fifo_q[wr_ptr_q] <= res[0];
		end
		if (fire && (res_count == paf_pkg::CNT_BITS'(paf_pkg::MAX_RESULTS))) begin
			fifo_q[wr_ptr_q + 1'b1] <= res[1];
		end
	end

	assign head     = fifo_q[rd_ptr_q];
	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = {3'b000, head.body_done, head.analog_value, head.action_id,
		head.slot_index};
	assign m_tuser  = head.is_analog;
	assign m_tlast  = head.last_of_run;

endmodule

### design/paf_unpack.sv
// Bit buffer, slot state and combinational field decode for one body byte.
module paf_unpack #(
	parameter int SLOT_COUNT = paf_pkg::SLOT_COUNT_DEFAULT,
	parameter int ID_BITS    = paf_pkg::ID_BITS_DEFAULT,
	parameter int VALUE_BITS = paf_pkg::VALUE_BITS_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [paf_pkg::THRESH_BITS-1:0]      threshold,
	input  logic                                 fire,
	input  logic [paf_pkg::BYTE_BITS-1:0]        byte_in,
	input  logic                                 start,
	output paf_pkg::result_t                     res [paf_pkg::MAX_RESULTS],
	output logic [paf_pkg::CNT_BITS-1:0]         res_count
);

	localparam int SLOT_W = $clog2(SLOT_COUNT + 1);
	localparam int ACC    = paf_pkg::ACC_BITS;
	localparam int HB     = paf_pkg::HELD_BITS;
	localparam int STEPS  = 2 * paf_pkg::MAX_RESULTS;

	// The bit buffer is kept left aligned: the oldest unread bit sits at the top.
	logic [paf_pkg::STORE_BITS-1:0] store_q, store_n;
	logic [HB-1:0]                  held_q, held_n;
	logic [SLOT_W-1:0]              slot_q, slot_n;
	logic                           await_q, await_n;
	logic [ID_BITS-1:0]             hid_q, hid_n;
	logic                           fin_q, fin_n;

	always_comb begin : decode
		logic [ACC-1:0]                       acc;
		logic [HB-1:0]                        total;
		logic [HB-1:0]                        need;
		logic [paf_pkg::STORE_BITS-1:0]       base_store;
		logic [HB-1:0]                        base_held;
		logic [SLOT_W-1:0]                    slot;
		logic                                 aw;
		logic [ID_BITS-1:0]                   hid;
		logic                                 fin;
		logic                                 idle;
		logic [paf_pkg::CNT_BITS-1:0]         cnt;
		logic [ID_BITS-1:0]                   id_f;
		logic [VALUE_BITS-1:0]                val_f;
		logic [paf_pkg::ID_BITS_MAX-1:0]      id_ext;
		logic [paf_pkg::VALUE_BITS_MAX-1:0]   val_ext;
		logic [paf_pkg::SLOT_EXT_BITS-1:0]    slot_ext;
		logic                                 emit;
		logic                                 emit_analog;

		for (int r = 0; r < paf_pkg::MAX_RESULTS; r++) begin
			res[r] = '0;
		end
		acc         = '0;
		total       = '0;
		need        = '0;
		id_f        = '0;
		val_f       = '0;
		id_ext      = '0;
		val_ext     = '0;
		slot_ext    = '0;
		emit        = 1'b0;
		emit_analog = 1'b0;
		cnt         = '0;

		// A start request clears everything before its byte is decoded.
		base_store = start ? '0 : store_q;
		base_held  = start ? '0 : held_q;
		slot = start ? '0 : slot_q;
		aw   = start ? 1'b0 : await_q;
		hid  = start ? '0 : hid_q;
		fin  = start ? 1'b0 : fin_q;
		idle = fin;

		if (!idle) begin
			acc   = {base_store, {paf_pkg::BYTE_BITS{1'b0}}}
				| ({byte_in, {paf_pkg::STORE_BITS{1'b0}}} >> base_held);
			total = base_held + HB'(paf_pkg::BYTE_BITS);
		end

		for (int k = 0; k < STEPS; k++) begin
			need = aw ? HB'(VALUE_BITS) : HB'(ID_BITS);
			emit = 1'b0;
			if ((cnt < paf_pkg::CNT_BITS'(paf_pkg::MAX_RESULTS)) && !fin
					&& (total >= need)) begin
				id_f  = acc[ACC-1 -: ID_BITS];
				val_f = acc[ACC-1 -: VALUE_BITS];
				acc   = aw ? (acc << VALUE_BITS) : (acc << ID_BITS);
				total = total - need;
				if (aw) begin
					emit        = 1'b1;
					emit_analog = 1'b1;
					id_f        = hid;
					aw          = 1'b0;
					hid         = '0;
				end else if ({1'b0, paf_pkg::ID_BITS_MAX'(id_f)} >=
						(paf_pkg::ID_BITS_MAX + 1)'(threshold)) begin
					aw  = 1'b1;
					hid = id_f;
				end else begin
					emit        = 1'b1;
					emit_analog = 1'b0;
				end
				if (emit) begin
					id_ext   = paf_pkg::ID_BITS_MAX'(id_f);
					val_ext  = paf_pkg::VALUE_BITS_MAX'(val_f);
					slot_ext = paf_pkg::SLOT_EXT_BITS'(slot);
					res[cnt[0]].slot_index   = slot_ext[paf_pkg::SLOT_IDX_BITS-1:0];
					res[cnt[0]].is_analog    = emit_analog;
					res[cnt[0]].action_id    = id_ext[paf_pkg::ACT_ID_BITS-1:0];
					res[cnt[0]].analog_value = emit_analog ?
						val_ext[paf_pkg::AVALUE_BITS-1:0] : '0;
					res[cnt[0]].body_done    =
						((SLOT_W + 1)'(slot) + 1'b1) >= (SLOT_W + 1)'(SLOT_COUNT);
					id_ext = '0;
					cnt    = cnt + 1'b1;
					slot   = slot + 1'b1;
					if (slot >= SLOT_W'(SLOT_COUNT)) begin
						// Body complete: whatever bits are left are thrown away.
						fin   = 1'b1;
						total = '0;
						acc   = '0;
					end
				end
			end
		end

		if (cnt != '0) begin
			res[cnt[0] ^ 1'b1].last_of_run = 1'b1;
		end
		res_count = cnt;

		if (idle) begin
			store_n = start ? '0 : store_q;
			held_n  = start ? '0 : held_q;
		end else begin
			// Only the oldest bits survive when more than the buffer can hold remain.
			store_n = acc[ACC-1 -: paf_pkg::STORE_BITS];
			held_n  = (total > HB'(paf_pkg::STORE_BITS)) ? HB'(paf_pkg::STORE_BITS) : total;
		end
		slot_n  = slot;
		await_n = aw;
		hid_n   = hid;
		fin_n   = fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			slot_q  <= '0;
			await_q <= 1'b0;
			hid_q   <= '0;
			fin_q   <= 1'b1;
		end else if (fire) begin
			held_q  <= held_n;
			slot_q  <= slot_n;
			await_q <= await_n;
			hid_q   <= hid_n;
			fin_q   <= fin_n;
		end
	end

	// Bits below the held count are always zero, so the buffer needs no reset
	// beyond the cleared count; it is still cleared to keep the invariant.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q <= '0;
		end else if (fire) begin
			store_q <= store_n;
		end
	end

endmodule

### dv/packed_action_field_unpacker_test.sv
// Self-checking testbench for the packed action field unpacker, with its own decode predictor.
`timescale 1ns / 100ps

module packed_action_field_unpacker_test;

	localparam int SLOTS          = paf_pkg::SLOT_COUNT_DEFAULT;
	localparam int ID_W           = paf_pkg::ID_BITS_DEFAULT;
	localparam int VAL_W          = paf_pkg::VALUE_BITS_DEFAULT;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_HOLD      = 300;
	localparam int DRAIN_CYCLES   = 8;
	localparam int ITEMS_PER_PHASE = 117;
	localparam int PHASES         = 6;
	localparam int MAX_PRINTS     = 50;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_wr_en;
	logic [paf_pkg::THRESH_BITS-1:0] cfg_wr_data;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [paf_pkg::BYTE_BITS-1:0]   s_tdata;
	logic                            s_tuser;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [paf_pkg::TDATA_BITS-1:0]  m_tdata;
	logic                            m_tuser;
	logic                            m_tlast;

	packed_action_field_unpacker DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Predictor copy of the decode state and the threshold register.
	logic [paf_pkg::THRESH_BITS-1:0] thresh_mdl;
	logic [15:0]                     store_mdl;
	int                              held_mdl;
	int                              slot_mdl;
	bit                              await_mdl;
	logic [7:0]                      pend_id_mdl;
	bit                              done_mdl;
	paf_pkg::result_t                decoded [2];

	paf_pkg::result_t pending_entries [$];

	int  errors;
	int  bytes_decoded;
	int  bytes_ignored;
	int  entries_seen;
	int  bodies_done;
	int  quiet_cycles;
	int  gap_pct;
	int  stall_pct;
	bit  calm;
	bit  held_long;
	string thresh_list;

	typedef struct {
		logic [7:0]       body_byte;
		bit               body_start;
		bit               typed;
		int               n_typed;
		paf_pkg::result_t e0;
		paf_pkg::result_t e1;
	} dir_row_t;

	dir_row_t directed_rows [$];

	function automatic paf_pkg::result_t mk_entry(input int slot, input bit analog,
			input int id, input int value, input bit done, input bit last);
		paf_pkg::result_t r;
		r.slot_index   = slot[4:0];
		r.is_analog    = analog;
		r.action_id    = id[4:0];
		r.analog_value = value[9:0];
		r.body_done    = done;
		r.last_of_run  = last;
		return r;
	endfunction

	// Decodes one accepted byte into the entries it completes. Returns -1 when the
	// byte is ignored because no body is open.
	function automatic int unpack_byte(input logic [7:0] b, input bit st);
		logic [23:0] acc;
		logic [23:0] field;
		int total;
		int cnt;
		int need;
		cnt = 0;
		if (st) begin
			store_mdl   = '0;
			held_mdl    = 0;
			slot_mdl    = 0;
			await_mdl   = 1'b0;
			pend_id_mdl = '0;
			done_mdl    = 1'b0;
		end
		if (done_mdl)
			return -1;
		acc   = {store_mdl, b};
		total = held_mdl + 8;
		while (cnt < 2 && !done_mdl) begin
			need = await_mdl ? VAL_W : ID_W;
			if (total < need)
				break;
			field = (acc >> (total - need)) & ((24'd1 << need) - 24'd1);
			total -= need;
			acc &= (24'd1 << total) - 24'd1;
			if (await_mdl) begin
				decoded[cnt] = mk_entry(slot_mdl, 1'b1, pend_id_mdl, field,
					slot_mdl + 1 >= SLOTS, 1'b0);
				cnt++;
				await_mdl   = 1'b0;
				pend_id_mdl = '0;
			end else if (field >= thresh_mdl) begin
				await_mdl   = 1'b1;
				pend_id_mdl = field[7:0];
				continue;
			end else begin
				decoded[cnt] = mk_entry(slot_mdl, 1'b0, field, 0, slot_mdl + 1 >= SLOTS, 1'b0);
				cnt++;
			end
			slot_mdl++;
			if (slot_mdl >= SLOTS) begin
				// Leftover bits of a finished body are thrown away.
				done_mdl = 1'b1;
				total    = 0;
				acc      = '0;
			end
		end
		if (total > 16) begin
			acc >>= (total - 16);
			total = 16;
		end
		store_mdl = acc[15:0];
		held_mdl  = total;
		if (cnt > 0)
			decoded[cnt-1].last_of_run = 1'b1;
		return cnt;
	endfunction

	task automatic report_error(input string msg);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("[%0t] ERROR: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_error($sformatf("entry %0d field %s: got %0d, expected %0d",
				entries_seen, name, got, want));
	endtask

	// Offers one byte, waits for the request to be taken, then predicts its entries.
	task automatic send_byte(input logic [7:0] b, input bit st, input bit typed,
			input int n_typed, input paf_pkg::result_t t0, input paf_pkg::result_t t1);
		int got;
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= st;
		do @(posedge clk); while (!s_tready);
		got = unpack_byte(b, st);
		if (got < 0)
			bytes_ignored++;
		else
			bytes_decoded++;
		if (typed) begin
			if (n_typed > 0)
				pending_entries = {pending_entries, t0};
			if (n_typed > 1)
				pending_entries = {pending_entries, t1};
		end else begin
			for (int i = 0; i < got; i++)
				pending_entries = {pending_entries, decoded[i]};
		end
		@(negedge clk);
	endtask

	// Lets the block drain so that the threshold can be changed safely.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_entries.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_threshold(input int value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value[paf_pkg::THRESH_BITS-1:0];
		@(negedge clk);
		cfg_wr_en  <= 1'b0;
		thresh_mdl = value[paf_pkg::THRESH_BITS-1:0];
		thresh_list = {thresh_list, $sformatf(" %0d", value)};
	endtask

	// Sends one well-formed body with random ids and values, optionally cut short.
	task automatic play_body(input bit cut);
		bit   bits [$];
		int   n_bytes;
		int   keep;
		int   id;
		int   value;
		int   t;
		bit   analog;
		logic [7:0] b;
		t = thresh_mdl;
		for (int s = 0; s < SLOTS; s++) begin
			analog = (t == 0) ? 1'b1 : bit'($urandom_range(0, 1));
			id = analog ? $urandom_range(t, 31) : $urandom_range(0, t - 1);
			for (int k = ID_W - 1; k >= 0; k--)
				bits = {bits, bit'(id[k])};
			if (analog) begin
				value = $urandom_range(0, 1023);
				for (int k = VAL_W - 1; k >= 0; k--)
					bits = {bits, bit'(value[k])};
			end
		end
		while (bits.size() % 8 != 0)
			bits = {bits, bit'($urandom_range(0, 1))};
		n_bytes = bits.size() / 8;
		keep = cut ? $urandom_range(1, n_bytes - 1) : n_bytes;
		for (int i = 0; i < keep; i++) begin
			for (int k = 0; k < 8; k++)
				b[7-k] = bits[i*8 + k];
			send_byte(b, i == 0, 1'b0, 0, '0, '0);
		end
		// Trailing bytes after a complete body must be ignored.
		if (!cut)
			repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0, 1'b0, 0, '0, '0);
	endtask

	task automatic add_row(input logic [7:0] b, input bit st, input bit typed, input int n,
			input paf_pkg::result_t e0, input paf_pkg::result_t e1);
		dir_row_t r;
		r.body_byte  = b;
		r.body_start = st;
		r.typed      = typed;
		r.n_typed    = n;
		r.e0         = e0;
		r.e1         = e1;
		directed_rows = {directed_rows, r};
	endtask

	// Result side: random stall bursts, and one long hold-off so the queue fills up.
	initial begin
		int hold_count;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held_long && !calm && entries_seen >= 150 && s_tvalid) begin
				m_tready <= 1'b0;
				hold_count = 0;
				while (hold_count < LONG_HOLD) begin
					@(negedge clk);
					hold_count++;
				end
				held_long = 1'b1;
			end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 17) - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_entries
		paf_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_entries.size() == 0) begin
				report_error($sformatf("entry with nothing expected: tdata %h tuser %b tlast %b",
					m_tdata, m_tuser, m_tlast));
			end else begin
				want = pending_entries.pop_front();
				check_field("slot_index", m_tdata[4:0], want.slot_index);
				check_field("action_id", m_tdata[9:5], want.action_id);
				check_field("analog_value", m_tdata[19:10], want.analog_value);
				check_field("body_done", m_tdata[20], want.body_done);
				check_field("tdata padding", m_tdata[23:21], 0);
				check_field("is_analog", m_tuser, want.is_analog);
				check_field("last_of_run", m_tlast, want.last_of_run);
				if (want.body_done)
					bodies_done++;
			end
			entries_seen++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] ERROR: no request moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int thresholds [PHASES];
		int phase_start;
		int mode;
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = 1'b0;
		errors      = 0;
		calm        = 1'b0;
		held_long   = 1'b0;
		gap_pct     = 20;
		stall_pct   = 15;
		thresh_list = " 16";
		thresh_mdl  = paf_pkg::THRESH_RESET;
		store_mdl   = '0;
		held_mdl    = 0;
		slot_mdl    = 0;
		await_mdl   = 1'b0;
		pend_id_mdl = '0;
		done_mdl    = 1'b1;

		// Directed part at the reset threshold of 16.
		add_row(8'hFF, 1'b0, 1'b1, 0, '0, '0);  // no body open yet
		add_row(8'h00, 1'b1, 1'b1, 1, mk_entry(0, 0, 0, 0, 0, 1), '0);
		add_row(8'h00, 1'b0, 1'b1, 2, mk_entry(1, 0, 0, 0, 0, 0), mk_entry(2, 0, 0, 0, 0, 1));
		add_row(8'hFF, 1'b1, 1'b1, 0, '0, '0);  // restart, analog id 31 waits for its value
		add_row(8'hFF, 1'b0, 1'b1, 1, mk_entry(0, 1, 31, 1023, 0, 1), '0);
		add_row(8'hFF, 1'b0, 1'b0, 0, '0, '0);
		// A start in the middle of a body, then all-digital zeros up to the last slot.
		add_row(8'h00, 1'b1, 1'b0, 0, '0, '0);
		repeat (12) add_row(8'h00, 1'b0, 1'b0, 0, '0, '0);
		add_row(8'h5A, 1'b0, 1'b1, 0, '0, '0);  // body complete, byte ignored
		add_row(8'hC3, 1'b1, 1'b0, 0, '0, '0);
		add_row(8'h81, 1'b0, 1'b0, 0, '0, '0);
		add_row(8'h7E, 1'b0, 1'b0, 0, '0, '0);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_byte(directed_rows[i].body_byte, directed_rows[i].body_start,
				directed_rows[i].typed, directed_rows[i].n_typed,
				directed_rows[i].e0, directed_rows[i].e1);

		thresholds = '{0, 31, 1, 16, 0, 8};
		thresholds[4] = $urandom_range(0, 31);
		for (int p = 0; p < PHASES; p++) begin
			settle();
			write_threshold(thresholds[p]);
			calm      = (p == PHASES - 1);
			gap_pct   = (p % 3 == 1) ? 0 : 25;
			stall_pct = (p % 3 == 2) ? 0 : 20;
			phase_start = bytes_decoded;
			while (bytes_decoded - phase_start < ITEMS_PER_PHASE) begin
				mode = $urandom_range(0, 9);
				if (mode <= 6) begin
					play_body(1'b0);
				end else if (mode == 7) begin
					play_body(1'b1);
				end else if (mode == 8) begin
					repeat ($urandom_range(1, 6))
						send_byte(8'($urandom), $urandom_range(0, 3) == 0, 1'b0, 0, '0, '0);
				end else begin
					send_byte(8'($urandom), 1'b1, 1'b0, 0, '0, '0);
					repeat ($urandom_range(1, 39))
						send_byte(8'($urandom), 1'b0, 1'b0, 0, '0, '0);
				end
			end
		end

		settle();
		if (pending_entries.size() != 0)
			report_error($sformatf("%0d entries never arrived", pending_entries.size()));
		$display("Run covered %0d decoded bytes, %0d ignored bytes, %0d entries, %0d full bodies.",
			bytes_decoded, bytes_ignored, entries_seen, bodies_done);
		$display("Thresholds used:%s; long output hold-off %s.", thresh_list,
			held_long ? "done" : "not reached");
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
